// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pesu_pkg.sv -----
`default_nettype none
package pesu_pkg;

  localparam int NUM_QUANT_REGS_DEF = 8;

  // Request codes
  localparam logic [1:0] REQ_SPR_WR = 2'd0;
  localparam logic [1:0] REQ_SPR_RD = 2'd1;
  localparam logic [1:0] REQ_MSR_WR = 2'd2;
  localparam logic [1:0] REQ_EXC    = 2'd3;

  // Exception kinds
  localparam logic [2:0] EXC_DSI = 3'd0;
  localparam logic [2:0] EXC_ISI = 3'd1;
  localparam logic [2:0] EXC_EXT = 3'd2;
  localparam logic [2:0] EXC_DEC = 3'd3;
  localparam logic [2:0] EXC_SC  = 3'd4;
  localparam logic [2:0] EXC_ICI = 3'd5;

  // Local SPR numbers
  localparam logic [9:0] SPR_XER   = 10'd1;
  localparam logic [9:0] SPR_LR    = 10'd8;
  localparam logic [9:0] SPR_CTR   = 10'd9;
  localparam logic [9:0] SPR_DSISR = 10'd18;
  localparam logic [9:0] SPR_DAR   = 10'd19;
  localparam logic [9:0] SPR_SRR0  = 10'd26;
  localparam logic [9:0] SPR_SRR1  = 10'd27;
  localparam logic [9:0] SPR_UTBL  = 10'd268;
  localparam logic [9:0] SPR_UTBU  = 10'd269;
  localparam logic [9:0] SPR_SPRG0 = 10'd272;
  localparam logic [9:0] SPR_SPRG1 = 10'd273;
  localparam logic [9:0] SPR_SPRG2 = 10'd274;
  localparam logic [9:0] SPR_SPRG3 = 10'd275;
  localparam logic [9:0] SPR_TBL   = 10'd284;
  localparam logic [9:0] SPR_TBU   = 10'd285;
  localparam logic [9:0] SPR_UGQR0 = 10'd896;
  localparam logic [9:0] SPR_GQR0  = 10'd912;
  localparam logic [9:0] SPR_UPIR  = 10'd1007;
  localparam logic [9:0] SPR_THRM3 = 10'd1022;

  localparam logic [31:0] MSR_EE     = 32'h0000_8000;
  localparam logic [31:0] SAVE_MASK  = 32'h0000_FF73;
  localparam logic [31:0] CLEAR_MASK = 32'h0004_EF70;
  localparam logic [31:0] MSR_RI     = 32'h0000_0002;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  spr_number;
    logic [31:0] write_value;
    logic [2:0]  exception_kind;
    logic [31:0] current_pc;
  } in_payload_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        redirect;
    logic [31:0] new_pc;
    logic        unhandled_spr;
    logic        msr_changed;
    logic [31:0] msr_out;
  } out_payload_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic msr_ee;
    logic dec_pending;
    logic ici_pending;
  } status_t;

  function automatic logic [31:0] exc_vector(input logic [2:0] kind);
    logic [31:0] v;
    case (kind)
      EXC_DSI: v = 32'hFFF0_0300;
      EXC_ISI: v = 32'hFFF0_0400;
      EXC_EXT: v = 32'hFFF0_0500;
      EXC_DEC: v = 32'hFFF0_0900;
      EXC_SC:  v = 32'hFFF0_0C00;
      EXC_ICI: v = 32'hFFF0_1700;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pesu_in_if.sv -----
`default_nettype none
interface pesu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [9:0]  spr_number;
  logic [31:0] write_value;
  logic [2:0]  exception_kind;
  logic [31:0] current_pc;

  modport source (output valid, req_type, spr_number, write_value, exception_kind,
                  current_pc, input ready);
  modport sink (input valid, req_type, spr_number, write_value, exception_kind,
                current_pc, output ready);
endinterface
`default_nettype wire

// ----- rtl/pesu_out_if.sv -----
`default_nettype none
interface pesu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic        redirect;
  logic [31:0] new_pc;
  logic        unhandled_spr;
  logic        msr_changed;
  logic [31:0] msr_out;

  modport source (output valid, read_value, redirect, new_pc, unhandled_spr,
                  msr_changed, msr_out, input ready);
  modport sink (input valid, read_value, redirect, new_pc, unhandled_spr,
                msr_changed, msr_out, output ready);
endinterface
`default_nettype wire

// ----- rtl/pesu_ctrl.sv -----
`default_nettype none
module pesu_ctrl
  import pesu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   exec;

  assign exec      = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign cmd.load  = in_valid && in_ready_r;
  assign cmd.exec  = exec;
  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            state_r    <= S_EXEC;
            in_ready_r <= 1'b0;
          end
          if (out_ready) out_valid_r <= 1'b0;
        end
        S_EXEC: begin
          if (exec) begin
            state_r     <= S_IDLE;
            in_ready_r  <= 1'b1;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pesu_dp.sv -----
`default_nettype none
module pesu_dp
  import pesu_pkg::*;
#(
  parameter int NUM_QUANT_REGS = NUM_QUANT_REGS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cmd_t         cmd,
  input  wire in_payload_t  in_data,
  output out_payload_t      out_data,
  output status_t           status
);

  localparam int QIDX_W = (NUM_QUANT_REGS > 1) ? $clog2(NUM_QUANT_REGS) : 1;

  in_payload_t  item_r;
  out_payload_t out_r;

  logic [31:0] msr_r, msr_nxt;
  logic [31:0] srr0_r, srr0_nxt;
  logic [31:0] srr1_r, srr1_nxt;
  logic [31:0] lcx_r [3];
  logic [31:0] lcx_nxt [3];
  logic [31:0] sprg_r [4];
  logic [31:0] sprg_nxt [4];
  logic [31:0] misc_r [4];
  logic [31:0] misc_nxt [4];
  logic [31:0] quant_r [NUM_QUANT_REGS];
  logic [31:0] quant_nxt [NUM_QUANT_REGS];
  logic [63:0] tb_r, tb_nxt;
  logic        decp_r, decp_nxt;
  logic        icip_r, icip_nxt;

  logic              quant_hit;
  logic [QIDX_W-1:0] qidx;
  logic              take;
  logic [2:0]        take_kind;
  logic [31:0]       msr_base;
  logic              held;
  out_payload_t      res;

  assign quant_hit = ((item_r.spr_number[9:3] == SPR_UGQR0[9:3]) ||
                      (item_r.spr_number[9:3] == SPR_GQR0[9:3])) &&
                     ({1'b0, item_r.spr_number[2:0]} < 4'(NUM_QUANT_REGS));
  assign qidx = item_r.spr_number[QIDX_W-1:0];

  always_comb begin
    msr_nxt   = msr_r;
    srr0_nxt  = srr0_r;
    srr1_nxt  = srr1_r;
    lcx_nxt   = lcx_r;
    sprg_nxt  = sprg_r;
    misc_nxt  = misc_r;
    quant_nxt = quant_r;
    tb_nxt    = tb_r;
    decp_nxt  = decp_r;
    icip_nxt  = icip_r;
    take      = 1'b0;
    take_kind = item_r.exception_kind;
    msr_base  = msr_r;
    held      = 1'b0;
    res       = '0;

    case (item_r.req_type)
      REQ_SPR_WR: begin
        unique case (item_r.spr_number)
          SPR_LR:    lcx_nxt[0]  = item_r.write_value;
          SPR_CTR:   lcx_nxt[1]  = item_r.write_value;
          SPR_XER:   lcx_nxt[2]  = item_r.write_value;
          SPR_SPRG0: sprg_nxt[0] = item_r.write_value;
          SPR_SPRG1: sprg_nxt[1] = item_r.write_value;
          SPR_SPRG2: sprg_nxt[2] = item_r.write_value;
          SPR_SPRG3: sprg_nxt[3] = item_r.write_value;
          SPR_UPIR:  misc_nxt[0] = item_r.write_value;
          SPR_THRM3: misc_nxt[1] = item_r.write_value;
          SPR_DSISR: misc_nxt[2] = item_r.write_value;
          SPR_DAR:   misc_nxt[3] = item_r.write_value;
          SPR_SRR0:  srr0_nxt    = item_r.write_value;
          SPR_SRR1:  srr1_nxt    = item_r.write_value;
          SPR_TBL:   tb_nxt      = {tb_r[63:32], item_r.write_value};
          SPR_TBU:   tb_nxt      = {item_r.write_value, tb_r[31:0]};
          default: begin
            if (quant_hit) quant_nxt[qidx] = item_r.write_value;
            else res.unhandled_spr = 1'b1;
          end
        endcase
      end
      REQ_SPR_RD: begin
        unique case (item_r.spr_number)
          SPR_LR:    res.read_value = lcx_r[0];
          SPR_CTR:   res.read_value = lcx_r[1];
          SPR_XER:   res.read_value = lcx_r[2];
          SPR_SPRG0: res.read_value = sprg_r[0];
          SPR_SPRG1: res.read_value = sprg_r[1];
          SPR_SPRG2: res.read_value = sprg_r[2];
          SPR_SPRG3: res.read_value = sprg_r[3];
          SPR_UPIR:  res.read_value = misc_r[0];
          SPR_THRM3: res.read_value = misc_r[1];
          SPR_DSISR: res.read_value = misc_r[2];
          SPR_DAR:   res.read_value = misc_r[3];
          SPR_SRR0:  res.read_value = srr0_r;
          SPR_SRR1:  res.read_value = srr1_r;
          SPR_UTBL:  res.read_value = tb_r[31:0];
          SPR_UTBU:  res.read_value = tb_r[63:32];
          default: begin
            if (quant_hit) res.read_value = quant_r[qidx];
            else res.unhandled_spr = 1'b1;
          end
        endcase
      end
      REQ_MSR_WR: begin
        msr_nxt         = item_r.write_value;
        msr_base        = item_r.write_value;
        res.msr_changed = 1'b1;
        if ((item_r.write_value & MSR_EE) != '0) begin
          if (decp_r) begin
            decp_nxt  = 1'b0;
            take      = 1'b1;
            take_kind = EXC_DEC;
          end else if (icip_r) begin
            icip_nxt  = 1'b0;
            take      = 1'b1;
            take_kind = EXC_ICI;
          end
        end
      end
      default: begin
        if (item_r.exception_kind <= EXC_ICI) begin
          if ((msr_r & MSR_EE) == '0) begin
            case (item_r.exception_kind)
              EXC_EXT: held = 1'b1;
              EXC_DEC: begin held = 1'b1; decp_nxt = 1'b1; end
              EXC_ICI: begin held = 1'b1; icip_nxt = 1'b1; end
              default: held = 1'b0;
            endcase
          end
          if (!held) begin
            take            = 1'b1;
            res.msr_changed = 1'b1;
          end
        end
      end
    endcase

    if (take) begin
      srr0_nxt     = (take_kind == EXC_DSI) ? item_r.current_pc - 32'd4
                                            : item_r.current_pc;
      srr1_nxt     = (msr_base & SAVE_MASK) | MSR_RI;
      msr_nxt      = msr_base & ~CLEAR_MASK;
      res.redirect = 1'b1;
      res.new_pc   = exc_vector(take_kind);
    end
    res.msr_out = msr_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.exec) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msr_r  <= '0;
      srr0_r <= '0;
      srr1_r <= '0;
      tb_r   <= '0;
      decp_r <= 1'b0;
      icip_r <= 1'b0;
      for (int i = 0; i < 3; i++) lcx_r[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        sprg_r[i] <= '0;
        misc_r[i] <= '0;
      end
      for (int i = 0; i < NUM_QUANT_REGS; i++) quant_r[i] <= '0;
    end else if (cmd.exec) begin
      msr_r   <= msr_nxt;
      srr0_r  <= srr0_nxt;
      srr1_r  <= srr1_nxt;
      tb_r    <= tb_nxt;
      decp_r  <= decp_nxt;
      icip_r  <= icip_nxt;
      lcx_r   <= lcx_nxt;
      sprg_r  <= sprg_nxt;
      misc_r  <= misc_nxt;
      quant_r <= quant_nxt;
    end
  end

  assign out_data           = out_r;
  assign status.msr_ee      = msr_r[15];
  assign status.dec_pending = decp_r;
  assign status.ici_pending = icip_r;

endmodule
`default_nettype wire

// ----- rtl/ppc_exception_and_spr_unit.sv -----
// Exception entry and local SPR file for a PowerPC-style core.
// in_item (sink): one request per item - SPR write, SPR read, MSR write or
//   raised exception, with the core's current PC.
// out_item (source): exactly one result per item - read data, redirect flag
//   and vector, unhandled-SPR flag, MSR-written flag and the MSR after the item.
// Handshake: an accepted item is loaded into the input holding register and
//   executed once the output register is free or being taken; its result is
//   valid from then on. in_item.ready drops after each accept and stays low
//   until that item executes, as the controller loads and then executes the
//   single input holding register, so no new item is taken before then.
// A result waiting in the output register does not block the next accept;
//   if out_item.ready stays low, the following item waits in the holding
//   register until the output register is taken.
// Reset (rst_n low, synchronous): MSR, SRR0/1, LR/CTR/XER, SPRGs, UPIR,
//   THRM3, DSISR, DAR, time base, GQRs and both pending flags clear to zero;
//   the unit comes up ready with no result pending.
`default_nettype none
module ppc_exception_and_spr_unit
  import pesu_pkg::*;
#(
  parameter int NUM_QUANT_REGS = NUM_QUANT_REGS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pesu_in_if.sink     in_item,
  pesu_out_if.source  out_item
);

  `include "assert_macros.svh"

  cmd_t         cmd;
  status_t      status;
  in_payload_t  in_data;
  out_payload_t out_data;

  assign in_data.req_type       = in_item.req_type;
  assign in_data.spr_number     = in_item.spr_number;
  assign in_data.write_value    = in_item.write_value;
  assign in_data.exception_kind = in_item.exception_kind;
  assign in_data.current_pc     = in_item.current_pc;

  pesu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .cmd       (cmd)
  );

  pesu_dp #(
    .NUM_QUANT_REGS (NUM_QUANT_REGS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data),
    .status   (status)
  );

  assign out_item.read_value    = out_data.read_value;
  assign out_item.redirect      = out_data.redirect;
  assign out_item.new_pc        = out_data.new_pc;
  assign out_item.unhandled_spr = out_data.unhandled_spr;
  assign out_item.msr_changed   = out_data.msr_changed;
  assign out_item.msr_out       = out_data.msr_out;

  `ASSERT_CLK(a_busy_after_accept, in_item.valid && in_item.ready |=> !in_item.ready, "accepted while busy")
  `ASSERT_CLK(a_redirect_clears_ee, out_item.valid && out_item.redirect |-> !out_item.msr_out[15], "EE set after exception entry")
  `ASSERT_CLK(a_no_pending_with_ee, status.msr_ee |-> !(status.dec_pending || status.ici_pending), "exception pending while EE set")
  `ASSERT_CLK(a_unhandled_reads_zero, out_item.valid && out_item.unhandled_spr |-> out_item.read_value == 32'h0 && !out_item.redirect, "unhandled SPR with data")

endmodule
`default_nettype wire
